FILE: design/cprgb_pkg.sv
// ----------------------------------------------------------------------------
// cprgb_pkg: shared definitions for the camera pixel to RGB888 converter
// Format codes, pixel and group types, chroma coefficients and the clamp.
// ----------------------------------------------------------------------------
package cprgb_pkg;

   // Input format codes held in the format register.
   localparam logic [1:0] FMT_YUYV   = 2'd0;
   localparam logic [1:0] FMT_RGB24  = 2'd1;
   localparam logic [1:0] FMT_RGB565 = 2'd2;
   localparam logic [1:0] FMT_UYVY   = 2'd3;

   // Chroma offset and 8.8 fixed-point coefficients.
   localparam logic [8:0]         CHROMA_BIAS = 9'd128;
   localparam logic signed [17:0] COEF_RV     = 18'sd359;
   localparam logic signed [17:0] COEF_GU     = 18'sd88;
   localparam logic signed [17:0] COEF_GV     = 18'sd183;
   localparam logic signed [17:0] COEF_BU     = 18'sd454;

   // One RGB888 pixel; red sits in the lowest bits when packed.
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pix_type;

   // A decoded group handed from the input stage to the lanes and merge stage.
   typedef struct packed {
      logic              is_yuv;
      logic              first_only;
      logic [7:0]        y0;
      logic [7:0]        y1;
      logic signed [8:0] u;
      logic signed [8:0] v;
      pix_type           direct;
   } grp_type;

   // Floor shift by 8 of an 8.8 accumulator, then clamp to 0..255.
   function automatic logic [7:0] shift_clamp(input logic signed [17:0] acc);
      logic signed [9:0] q;
      q = 10'(acc >>> 8);
      if (q < 0) begin
         return 8'd0;
      end else if (q > 10'sd255) begin
         return 8'd255;
      end else begin
         return q[7:0];
      end
   endfunction

endpackage

FILE: design/cprgb_unpack.sv
// ----------------------------------------------------------------------------
// cprgb_unpack: input stage
// Registers one request and sorts its bytes into luma, chroma and direct RGB.
// ----------------------------------------------------------------------------
module cprgb_unpack
   import cprgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  fmt,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // byte0, byte1, byte2, byte3
   input  logic        req_tuser,   // first_only
   output logic        grp_valid,
   input  logic        grp_ready,
   output grp_type     grp
);

   logic    valid_ff, valid_in;
   grp_type grp_ff, grp_in;
   logic [7:0] b0, b1, b2, b3;

   assign b0 = req_tdata[7:0];
   assign b1 = req_tdata[15:8];
   assign b2 = req_tdata[23:16];
   assign b3 = req_tdata[31:24];

   // The stage refills whenever it is empty or its group moves on.
   assign req_tready = !valid_ff || grp_ready;

   // Decode the packed bytes according to the format.
   always_comb begin
      grp_in            = '0;
      grp_in.first_only = req_tuser;
      unique case (fmt)
         FMT_YUYV: begin
            grp_in.is_yuv = 1'b1;
            grp_in.y0     = b0;
            grp_in.u      = $signed({1'b0, b1} - CHROMA_BIAS);
            grp_in.y1     = b2;
            grp_in.v      = $signed({1'b0, b3} - CHROMA_BIAS);
         end
         FMT_UYVY: begin
            grp_in.is_yuv = 1'b1;
            grp_in.u      = $signed({1'b0, b0} - CHROMA_BIAS);
            grp_in.y0     = b1;
            grp_in.v      = $signed({1'b0, b2} - CHROMA_BIAS);
            grp_in.y1     = b3;
         end
         FMT_RGB24: begin
            grp_in.direct.red   = b0;
            grp_in.direct.green = b1;
            grp_in.direct.blue  = b2;
         end
         FMT_RGB565: begin
            grp_in.direct.red   = {b1[7:3], 3'b000};
            grp_in.direct.green = {b1[2:0], b0[7:5], 2'b00};
            grp_in.direct.blue  = {b0[4:0], 3'b000};
         end
         default: begin
            grp_in = '0;
         end
      endcase
   end

   assign valid_in = req_tready ? req_tvalid : valid_ff;

   // Control register with reset; payload loads on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         grp_ff <= grp_in;
      end
   end

   assign grp_valid = valid_ff;
   assign grp       = grp_ff;

endmodule

FILE: design/cprgb_lane.sv
// ----------------------------------------------------------------------------
// cprgb_lane: one YUV to RGB conversion lane
// Computes one pixel from its luma and the shared chroma pair.
// ----------------------------------------------------------------------------
module cprgb_lane
   import cprgb_pkg::*;
(
   input  logic [7:0]        y,
   input  logic signed [8:0] u,
   input  logic signed [8:0] v,
   output pix_type           pix
);

   logic signed [17:0] ys, u_ext, v_ext;
   logic signed [17:0] r_acc, g_acc, b_acc;

   assign ys    = $signed({2'b00, y, 8'b0});
   assign u_ext = 18'(u);
   assign v_ext = 18'(v);

   // Constant multiplies and sums in 8.8 fixed point.
   assign r_acc = ys + v_ext * COEF_RV;
   assign g_acc = ys - u_ext * COEF_GU - v_ext * COEF_GV;
   assign b_acc = ys + u_ext * COEF_BU;

   assign pix.red   = shift_clamp(r_acc);
   assign pix.green = shift_clamp(g_acc);
   assign pix.blue  = shift_clamp(b_acc);

endmodule

FILE: design/cprgb_merge.sv
// ----------------------------------------------------------------------------
// cprgb_merge: merging stage
// Collects a group's pixels and sends one per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
module cprgb_merge
   import cprgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        grp_valid,
   output logic        grp_ready,
   input  grp_type     grp,
   input  pix_type     lane0_pix,
   input  pix_type     lane1_pix,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red, green, blue
   output logic        rsp_tlast    // last
);

   logic [1:0] cnt_ff, cnt_in;
   pix_type    pix0_ff, pix0_in, pix1_ff, pix1_in;
   logic       last0_ff, last0_in;
   logic       load, take;

   // A new group loads when the buffer empties in this cycle at the latest.
   assign grp_ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign load      = grp_valid && grp_ready;
   assign take      = rsp_tvalid && rsp_tready;

   // Buffer update: load a group, or shift the second pixel to the head.
   always_comb begin
      cnt_in   = cnt_ff;
      pix0_in  = pix0_ff;
      pix1_in  = pix1_ff;
      last0_in = last0_ff;
      if (load) begin
         pix0_in  = grp.is_yuv ? lane0_pix : grp.direct;
         pix1_in  = lane1_pix;
         last0_in = !grp.is_yuv || grp.first_only;
         cnt_in   = (grp.is_yuv && !grp.first_only) ? 2'd2 : 2'd1;
      end else if (take) begin
         pix0_in  = pix1_ff;
         last0_in = 1'b1;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pix0_ff  <= pix0_in;
      pix1_ff  <= pix1_in;
      last0_ff <= last0_in;
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = pix0_ff;
   assign rsp_tlast  = last0_ff;

`ifndef ASSERT_OFF
   // The buffer never holds more than one group's two pixels.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("pixel buffer count out of range");

   // The head pixel carries the last flag exactly when it is the only one left.
   a_last_head: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (cnt_ff == 2'd1)))
      else $error("last flag does not match buffer fill");

   // Taking the first of two pixels brings the second one to the head.
   a_shift: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && take) |=> (cnt_ff == 2'd1 && pix0_ff == $past(pix1_ff)))
      else $error("second pixel lost on shift");
`endif

endmodule

FILE: design/camera_pixel_to_rgb888_core.sv
// ----------------------------------------------------------------------------
// camera_pixel_to_rgb888_core: camera pixel to RGB888 converter
// Path: the first pixel of a request passes the input-stage register and the
// merge buffer before it is valid on rsp.
// Throughput: one request per cycle for RGB24 and RGB565 and for single YUV
// pixels while rsp_tready is high; a full YUV group is two output pixels.
// Two conversion lanes handle both luma samples of a group at once.
// Reset: synchronous, active high; empties the pipeline and sets format YUYV.
// ----------------------------------------------------------------------------
module camera_pixel_to_rgb888_core
   import cprgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,  // input_format
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // byte0, byte1, byte2, byte3
   input  logic        req_tuser,    // first_only
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // red, green, blue
   output logic        rsp_tlast     // last
);

   logic [1:0] fmt_ff, fmt_in;
   logic       grp_valid, grp_ready;
   grp_type    grp;
   pix_type    lane0_pix, lane1_pix;

   // Format register.
   assign fmt_in = csr_wr_en ? csr_wr_data : fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_YUYV;
      end else begin
         fmt_ff <= fmt_in;
      end
   end

   // Input stage.
   cprgb_unpack u_unpack (
      .clock      (clock),
      .reset      (reset),
      .fmt        (fmt_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .grp_valid  (grp_valid),
      .grp_ready  (grp_ready),
      .grp        (grp)
   );

   // Conversion lanes, one per luma sample.
   cprgb_lane u_lane0 (
      .y   (grp.y0),
      .u   (grp.u),
      .v   (grp.v),
      .pix (lane0_pix)
   );

   cprgb_lane u_lane1 (
      .y   (grp.y1),
      .u   (grp.u),
      .v   (grp.v),
      .pix (lane1_pix)
   );

   // Merging stage and output.
   cprgb_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .grp_valid  (grp_valid),
      .grp_ready  (grp_ready),
      .grp        (grp),
      .lane0_pix  (lane0_pix),
      .lane1_pix  (lane1_pix),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: dv/tb_camera_pixel_to_rgb888_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_camera_pixel_to_rgb888_core: testbench for the camera pixel converter
// Packed camera groups in every input format go through the block, first as
// directed corner cases and then as random phases under varying flow control.
// A local converter predicts each RGB888 pixel and the monitor compares the
// pixels in order.
// ----------------------------------------------------------------------------
module tb_camera_pixel_to_rgb888_core;
   import cprgb_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 400;
   localparam int PHASES         = 12;
   localparam int PHASE_GROUPS   = 60;

   // One packed camera group as it travels on the request channel.
   typedef struct packed {
      logic       first_only;
      logic [7:0] byte3;
      logic [7:0] byte2;
      logic [7:0] byte1;
      logic [7:0] byte0;
   } cam_group_type;

   // One expected output pixel.
   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } rgb_pixel_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [1:0]  csr_wr_data = FMT_YUYV;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;    // byte0, byte1, byte2, byte3
   logic        req_tuser   = 1'b0;  // first_only
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;           // red, green, blue
   logic        rsp_tlast;           // last

   cam_group_type pending_groups[$];
   rgb_pixel_type expected_pixels[$];
   logic [1:0]    cur_format = FMT_YUYV;
   int            mismatch_count = 0;
   int            pixels_seen = 0;
   int            gap_max = 0;
   int            stall_pct = 0;
   bit            long_hold_done = 1'b0;

   camera_pixel_to_rgb888_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always #10 clock = ~clock;

   // Floor the 8.8 value to an integer and saturate it to a byte.
   function automatic logic [7:0] floor_saturate(input int acc);
      int q;
      q = acc >>> 8;
      if (q < 0) begin
         return 8'd0;
      end else if (q > 255) begin
         return 8'd255;
      end else begin
         return q[7:0];
      end
   endfunction

   // Converts one luma sample with the shared chroma pair of its group.
   function automatic rgb_pixel_type yuv_to_rgb(input logic [7:0] luma, input int cb,
                                                input int cr, input logic last);
      rgb_pixel_type px;
      int            base;
      base     = int'(luma) * 256;
      px.red   = floor_saturate(base + 359 * cr);
      px.green = floor_saturate(base - 88 * cb - 183 * cr);
      px.blue  = floor_saturate(base + 454 * cb);
      px.last  = last;
      return px;
   endfunction

   // Works out the pixels of one accepted group under the current format.
   function automatic void convert_group(input cam_group_type g);
      rgb_pixel_type px;
      logic [7:0]    y0, y1;
      int            cb, cr;
      logic [15:0]   word;
      case (cur_format) inside
         FMT_YUYV, FMT_UYVY: begin
            if (cur_format == FMT_YUYV) begin
               y0 = g.byte0; cb = int'(g.byte1) - 128; y1 = g.byte2; cr = int'(g.byte3) - 128;
            end else begin
               cb = int'(g.byte0) - 128; y0 = g.byte1; cr = int'(g.byte2) - 128; y1 = g.byte3;
            end
            if (g.first_only) begin
               expected_pixels.push_back(yuv_to_rgb(y0, cb, cr, 1'b1));
            end else begin
               expected_pixels.push_back(yuv_to_rgb(y0, cb, cr, 1'b0));
               expected_pixels.push_back(yuv_to_rgb(y1, cb, cr, 1'b1));
            end
         end
         FMT_RGB24: begin
            px.red   = g.byte0;
            px.green = g.byte1;
            px.blue  = g.byte2;
            px.last  = 1'b1;
            expected_pixels.push_back(px);
         end
         default: begin
            // RGB565 little-endian: high bits of each channel only.
            word     = {g.byte1, g.byte0};
            px.red   = g.byte1 & 8'hF8;
            px.green = 8'((word & 16'h07E0) >> 3);
            px.blue  = {g.byte0[4:0], 3'b000};
            px.last  = 1'b1;
            expected_pixels.push_back(px);
         end
      endcase
   endfunction

   function automatic void queue_group(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [7:0] b3,
                                       input logic fo);
      cam_group_type g;
      g = '{first_only: fo, byte3: b3, byte2: b2, byte1: b1, byte0: b0};
      pending_groups.push_back(g);
   endfunction

   // Random byte with extra weight on the two extremes.
   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      cam_group_type g;
      bit            offering;
      static int     burst_left = 0;
      static int     gap_left = 0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offering = req_tvalid;
         if (req_tvalid && req_tready) begin
            convert_group(cam_group_type'({req_tuser, req_tdata}));
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_groups.size() != 0) begin
               g = pending_groups.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {g.byte3, g.byte2, g.byte1, g.byte0};
               req_tuser  <= g.first_only;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = $urandom_range(0, gap_max);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Pixel monitor: checks each accepted pixel and drives the stall pattern.
   always @(posedge clock) begin
      rgb_pixel_type exp_px;
      static int     hold_left = 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel: tdata %06h tlast %0b", rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               exp_px = expected_pixels.pop_front();
               if (rsp_tdata[7:0] !== exp_px.red) begin
                  $error("red: expected %0d, actual %0d", exp_px.red, rsp_tdata[7:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[15:8] !== exp_px.green) begin
                  $error("green: expected %0d, actual %0d", exp_px.green, rsp_tdata[15:8]);
                  mismatch_count++;
               end
               if (rsp_tdata[23:16] !== exp_px.blue) begin
                  $error("blue: expected %0d, actual %0d", exp_px.blue, rsp_tdata[23:16]);
                  mismatch_count++;
               end
               if (rsp_tlast !== exp_px.last) begin
                  $error("last: expected %0d, actual %0d", exp_px.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         // One long hold while plenty of requests are still queued fills the block.
         if (!long_hold_done && pixels_seen >= 150 && pending_groups.size() >= 20) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(1, 100) > stall_pct);
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      static int quiet_cycles = 0;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL camera_pixel_to_rgb888_core");
         $finish;
      end
   end

   // Waits until every queued request went in and every pixel came out.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_groups.size() != 0 || req_tvalid || expected_pixels.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_format(input logic [1:0] fmt);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fmt;
      cur_format   = fmt;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   // Stimulus: directed corners per format, then random phases.
   initial begin
      logic [1:0] phase_fmt;
      logic [1:0] first_formats[4];
      first_formats = '{FMT_UYVY, FMT_RGB565, FMT_RGB24, FMT_YUYV};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // YUYV from the reset value: chroma extremes, clamping and single pixels.
      queue_group(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_group(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0);
      queue_group(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0);
      queue_group(8'h80, 8'h80, 8'h80, 8'h80, 1'b0);
      queue_group(8'hC8, 8'h00, 8'h32, 8'hFF, 1'b1);
      queue_group(8'h10, 8'hFF, 8'hEB, 8'h00, 1'b1);
      wait_drained();

      // RGB24 passes bytes through; the single-pixel flag has no effect.
      write_format(FMT_RGB24);
      queue_group(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      queue_group(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
      wait_drained();

      // RGB565 with each channel isolated.
      write_format(FMT_RGB565);
      queue_group(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      queue_group(8'h1F, 8'h00, 8'hFF, 8'h00, 1'b0);
      queue_group(8'hE0, 8'h07, 8'h00, 8'hFF, 1'b0);
      queue_group(8'h00, 8'hF8, 8'h00, 8'h00, 1'b1);
      wait_drained();

      // UYVY with the same kind of corners as YUYV.
      write_format(FMT_UYVY);
      queue_group(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_group(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0);
      queue_group(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1);
      queue_group(8'h80, 8'hEB, 8'h80, 8'h10, 1'b1);
      queue_group(8'h5A, 8'h3C, 8'hF0, 8'hC8, 1'b0);
      wait_drained();

      // Random phases, every third one without any idling.
      for (int ph = 0; ph < PHASES; ph++) begin
         phase_fmt = (ph < 4) ? first_formats[ph] : 2'($urandom_range(0, 3));
         write_format(phase_fmt);
         if (ph % 3 == 0) begin
            gap_max   = 0;
            stall_pct = 0;
         end else begin
            gap_max   = $urandom_range(1, 8);
            stall_pct = $urandom_range(10, 60);
         end
         for (int n = 0; n < PHASE_GROUPS; n++) begin
            queue_group(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                        ($urandom_range(0, 3) == 0));
         end
         wait_drained();
      end

      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("PASS camera_pixel_to_rgb888_core");
      end else begin
         $display("FAIL camera_pixel_to_rgb888_core");
      end
      $finish;
   end

endmodule
